[rtl/ttf_pkg.sv]
// Shared types and constants for the triangle tangent frame block.
`timescale 1ns / 1ps
package ttf_pkg;

  // Output fraction bits (Q1.14).
  localparam int unsigned OutFracBits = 14;

  // Exact width of coordinate differences.
  localparam int unsigned DltW = 33;
  // Accumulator width for det, tangent and bitangent sums.
  localparam int unsigned AccW = 68;
  // Width of a product of two differences.
  localparam int unsigned ProdW = 2 * DltW;
  // Normalized magnitude width and dividend width.
  localparam int unsigned NrmW = 30;
  localparam int unsigned NumW = 46;

  typedef logic signed [DltW-1:0] dlt_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
  } vtx_t;

  typedef struct packed {
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic signed [15:0] bitangent_x;
    logic signed [15:0] bitangent_y;
    logic signed [15:0] bitangent_z;
    logic               degenerate;
  } res_t;

  // One closed triangle, reduced to edges and UV deltas.
  typedef struct packed {
    dlt_t       d1u;
    dlt_t       d1v;
    dlt_t       d2u;
    dlt_t       d2v;
    dlt_t [2:0] e1;
    dlt_t [2:0] e2;
  } job_t;

  // Queue status seen by the back end.
  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

endpackage

[rtl/ttf_fifo.sv]
// Two-entry job queue between the front end and the back end.
`timescale 1ns / 1ps
module ttf_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  ttf_pkg::job_t wdata_i,
  input  logic          rd_i,
  output ttf_pkg::job_t rdata_o,
  output ttf_pkg::qstat_t stat_o
);
  import ttf_pkg::*;

  job_t       mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_wr, do_rd;

  assign do_wr = wr_i && (cnt_q != 2'd2);
  assign do_rd = rd_i && (cnt_q != 2'd0);

  always_comb begin
    wptr_d = wptr_q ^ do_wr;
    rptr_d = rptr_q ^ do_rd;
    cnt_d  = cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  assign rdata_o      = mem_q[rptr_q];
  assign stat_o.empty = (cnt_q == 2'd0);
  assign stat_o.full  = (cnt_q == 2'd2);

endmodule

[rtl/ttf_front.sv]
// Front end: holds the first two vertices and forms edges and UV deltas.
`timescale 1ns / 1ps
module ttf_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ttf_pkg::vtx_t   vtx_i,
  output logic            full_o,
  input  ttf_pkg::qstat_t qstat_i,
  output logic            job_wr_o,
  output ttf_pkg::job_t   job_o
);
  import ttf_pkg::*;

  logic [1:0] phase_q, phase_d;
  vtx_t       v0_q, v1_q;
  logic       closing, accept;

  // phase three cannot arise; it closes like phase two
  assign closing = phase_q[1];
  assign full_o  = closing && qstat_i.full;
  assign accept  = push_i && !full_o;
  assign job_wr_o = accept && closing;

  function automatic dlt_t dif(logic signed [31:0] a, logic signed [31:0] b);
    dif = $signed({a[31], a}) - $signed({b[31], b});
  endfunction

  always_comb begin
    job_o.d1u   = dif(v1_q.tex_u, v0_q.tex_u);
    job_o.d1v   = dif(v1_q.tex_v, v0_q.tex_v);
    job_o.d2u   = dif(vtx_i.tex_u, v0_q.tex_u);
    job_o.d2v   = dif(vtx_i.tex_v, v0_q.tex_v);
    job_o.e1[0] = dif(v1_q.pos_x, v0_q.pos_x);
    job_o.e1[1] = dif(v1_q.pos_y, v0_q.pos_y);
    job_o.e1[2] = dif(v1_q.pos_z, v0_q.pos_z);
    job_o.e2[0] = dif(vtx_i.pos_x, v0_q.pos_x);
    job_o.e2[1] = dif(vtx_i.pos_y, v0_q.pos_y);
    job_o.e2[2] = dif(vtx_i.pos_z, v0_q.pos_z);
  end

  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      phase_d = closing ? 2'd0 : phase_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      v0_q    <= '0;
      v1_q    <= '0;
    end else begin
      phase_q <= phase_d;
      if (accept && phase_q == 2'd0) begin
        v0_q <= vtx_i;
      end
      if (accept && phase_q == 2'd1) begin
        v1_q <= vtx_i;
      end
    end
  end

endmodule

[rtl/ttf_back.sv]
// Back end: products, normalization, square root, division, result register.
`timescale 1ns / 1ps
module ttf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ttf_pkg::qstat_t qstat_i,
  input  ttf_pkg::job_t   job_i,
  output logic            job_rd_o,
  output logic            empty_o,
  input  logic            pop_i,
  output ttf_pkg::res_t   res_o
);
  import ttf_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_SQR   = 3'd4;
  localparam logic [2:0] S_SQRT  = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_WRITE = 3'd7;

  localparam logic [5:0] LastProd = 6'd13;
  localparam logic [5:0] LastSq   = 6'd2;
  localparam logic [5:0] LastRoot = 6'd30;
  localparam logic [5:0] LastDiv  = 6'(NumW - 1);
  localparam logic [NumW-1:0] QMax = NumW'(1) << OutFracBits;

  logic [2:0]  state_q;
  logic [5:0]  cnt_q;
  logic        half_q;
  logic        vec_q;
  logic [1:0]  comp_q;
  logic        degen_q;
  logic [2:0]  neg_q;
  job_t        job_q;

  logic signed [AccW-1:0]  acc_q [7];
  logic [AccW-1:0]         m_q [3];
  logic signed [ProdW-1:0] prod_q;
  logic [61:0]             len2_q, n_q, res_q, bit_q;
  logic [31:0]             len_q;
  logic [NumW-1:0]         num_q, quo_q;
  logic [32:0]             rem_q;
  logic [15:0]             rv_q [6];

  logic        ovalid_q;
  res_t        out_q;

  dlt_t        mul_a, mul_b;
  logic [AccW-1:0] mag [3];
  logic [AccW-1:0] mor;
  logic [2:0]  sel;
  logic [62:0] trial;
  logic [32:0] rem_sh;
  logic [NumW-1:0] quo_nx;
  logic [NumW-1:0] qcl;
  logic [15:0] qout;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_SQR) begin
      mul_a = dlt_t'({3'b000, m_q[cnt_q[1:0]][AccW-1 -: NrmW]});
      mul_b = mul_a;
    end else begin
      unique case (cnt_q)
        6'd0:  begin mul_a = job_q.d1u; mul_b = job_q.d2v;   end
        6'd1:  begin mul_a = job_q.d2u; mul_b = job_q.d1v;   end
        6'd2:  begin mul_a = job_q.d2v; mul_b = job_q.e1[0]; end
        6'd3:  begin mul_a = job_q.d1v; mul_b = job_q.e2[0]; end
        6'd4:  begin mul_a = job_q.d2v; mul_b = job_q.e1[1]; end
        6'd5:  begin mul_a = job_q.d1v; mul_b = job_q.e2[1]; end
        6'd6:  begin mul_a = job_q.d2v; mul_b = job_q.e1[2]; end
        6'd7:  begin mul_a = job_q.d1v; mul_b = job_q.e2[2]; end
        6'd8:  begin mul_a = job_q.d1u; mul_b = job_q.e2[0]; end
        6'd9:  begin mul_a = job_q.d2u; mul_b = job_q.e1[0]; end
        6'd10: begin mul_a = job_q.d1u; mul_b = job_q.e2[1]; end
        6'd11: begin mul_a = job_q.d2u; mul_b = job_q.e1[1]; end
        6'd12: begin mul_a = job_q.d1u; mul_b = job_q.e2[2]; end
        6'd13: begin mul_a = job_q.d2u; mul_b = job_q.e1[2]; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // magnitudes of the vector being normalized
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sel    = vec_q ? 3'(4 + i) : 3'(1 + i);
      mag[i] = acc_q[sel][AccW-1] ? AccW'(-acc_q[sel]) : AccW'(acc_q[sel]);
    end
    mor    = m_q[0] | m_q[1] | m_q[2];
    trial  = {1'b0, res_q} + {1'b0, bit_q};
    rem_sh = {rem_q[31:0], num_q[NumW-1]};
    quo_nx = {quo_q[NumW-2:0], (rem_sh >= {1'b0, len_q})};
    qcl    = (quo_nx > QMax) ? QMax : quo_nx;
    qout   = neg_q[comp_q] ? 16'(-qcl) : qcl[15:0];
  end

  assign job_rd_o = (state_q == S_IDLE) && !qstat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      half_q   <= 1'b0;
      vec_q    <= 1'b0;
      comp_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (pop_i && ovalid_q) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!qstat_i.empty) begin
            state_q <= S_MUL;
            cnt_q   <= '0;
            half_q  <= 1'b0;
            vec_q   <= 1'b0;
          end
        end
        S_MUL: begin
          half_q <= ~half_q;
          if (half_q) begin
            cnt_q <= cnt_q + 6'd1;
            if (cnt_q == LastProd) begin
              state_q <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          if (acc_q[0] == '0) begin
            state_q <= S_WRITE;
          end else if (mag[0] == '0 && mag[1] == '0 && mag[2] == '0) begin
            vec_q   <= 1'b1;
            state_q <= vec_q ? S_WRITE : S_LOAD;
          end else begin
            state_q <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (mor[AccW-1]) begin
            state_q <= S_SQR;
            cnt_q   <= '0;
            half_q  <= 1'b0;
          end
        end
        S_SQR: begin
          half_q <= ~half_q;
          if (half_q) begin
            if (cnt_q == LastSq) begin
              state_q <= S_SQRT;
              cnt_q   <= '0;
            end else begin
              cnt_q <= cnt_q + 6'd1;
            end
          end
        end
        S_SQRT: begin
          if (cnt_q == LastRoot) begin
            state_q <= S_DIV;
            cnt_q   <= '0;
            comp_q  <= '0;
            half_q  <= 1'b0;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        S_DIV: begin
          // half_q low: load dividend; high: one quotient bit per cycle
          if (!half_q) begin
            half_q <= 1'b1;
            cnt_q  <= '0;
          end else begin
            cnt_q <= cnt_q + 6'd1;
            if (cnt_q == LastDiv) begin
              half_q <= 1'b0;
              comp_q <= (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
              if (comp_q == 2'd2) begin
                vec_q   <= 1'b1;
                state_q <= vec_q ? S_WRITE : S_LOAD;
              end
            end
          end
        end
        S_WRITE: begin
          if (!ovalid_q) begin
            ovalid_q <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        job_q   <= job_i;
        degen_q <= 1'b0;
        for (int i = 0; i < 7; i++) acc_q[i] <= '0;
        for (int i = 0; i < 6; i++) rv_q[i] <= '0;
      end
      S_MUL: begin
        if (half_q) begin
          if (cnt_q[0]) begin
            acc_q[cnt_q[3:1]] <= acc_q[cnt_q[3:1]] - AccW'(prod_q);
          end else begin
            acc_q[cnt_q[3:1]] <= acc_q[cnt_q[3:1]] + AccW'(prod_q);
          end
        end
      end
      S_LOAD: begin
        len2_q <= '0;
        for (int i = 0; i < 3; i++) begin
          m_q[i]   <= mag[i];
          neg_q[i] <= acc_q[vec_q ? 3'(4 + i) : 3'(1 + i)][AccW-1] ^ acc_q[0][AccW-1];
        end
        if (acc_q[0] == '0 || (mag[0] == '0 && mag[1] == '0 && mag[2] == '0)) begin
          degen_q <= 1'b1;
        end
      end
      S_SHIFT: begin
        if (!mor[AccW-1]) begin
          for (int i = 0; i < 3; i++) begin
            m_q[i] <= (mor[AccW-1 -: 8] == '0) ? (m_q[i] << 8) : (m_q[i] << 1);
          end
        end
      end
      S_SQR: begin
        if (half_q) begin
          len2_q <= len2_q + prod_q[61:0];
        end
        n_q   <= len2_q + (half_q ? prod_q[61:0] : 62'd0);
        res_q <= '0;
        bit_q <= 62'd1 << 60;
      end
      S_SQRT: begin
        if ({1'b0, n_q} >= trial) begin
          n_q   <= n_q - trial[61:0];
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
        len_q <= ({1'b0, n_q} >= trial) ? 32'((res_q >> 1) + bit_q) : 32'(res_q >> 1);
      end
      S_DIV: begin
        if (!half_q) begin
          num_q <= (NumW'(m_q[comp_q][AccW-1 -: NrmW]) << OutFracBits)
                   + NumW'(len_q[31:1]);
          rem_q <= '0;
          quo_q <= '0;
        end else begin
          num_q <= num_q << 1;
          if (rem_sh >= {1'b0, len_q}) begin
            rem_q <= rem_sh - {1'b0, len_q};
            quo_q <= {quo_q[NumW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[NumW-2:0], 1'b0};
          end
        end
      end
      S_WRITE: begin
        if (!ovalid_q) begin
          out_q.tangent_x   <= rv_q[0];
          out_q.tangent_y   <= rv_q[1];
          out_q.tangent_z   <= rv_q[2];
          out_q.bitangent_x <= rv_q[3];
          out_q.bitangent_y <= rv_q[4];
          out_q.bitangent_z <= rv_q[5];
          out_q.degenerate  <= degen_q;
        end
      end
      default: ;
    endcase
    // store a finished component as its last quotient bit is formed
    if (state_q == S_DIV && half_q && cnt_q == LastDiv) begin
      rv_q[vec_q ? 3'(3 + comp_q) : 3'(comp_q)] <= qout;
    end
  end

  assign empty_o = !ovalid_q;
  assign res_o   = out_q;

`ifndef SYNTH
  // a nonzero vector is shifted until its largest component has its top bit set
  a_norm_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SQR |-> mor[AccW-1])
    else $error("normalization left no top bit");

  // the largest component lies in [2^29, 2^30), so the length does too or more
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && half_q) |-> len_q[31:29] != 3'b000)
    else $error("length below normalized range");

  // a new job is taken only from a nonempty queue while idle
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_rd_o |=> state_q == S_MUL && cnt_q == 6'd0)
    else $error("job taken without starting products");

  // a non-degenerate result never holds an all-zero tangent
  a_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !out_q.degenerate) |->
      (out_q.tangent_x != '0 || out_q.tangent_y != '0 || out_q.tangent_z != '0))
    else $error("zero tangent on a valid triangle");
`endif

endmodule

[rtl/triangle_tangent_frame.sv]
// Top level of the per-triangle tangent and bitangent unit.
//
// Input queue: one vertex per request (Q16.16 position and UV); taken
// when push is high and full is low. Every third vertex closes a
// triangle; full rises only on that vertex while the job queue is full.
// Result queue: one tangent/bitangent pair (Q1.14) plus a degenerate
// flag per triangle; valid while empty is low, taken when pop is high.
// The front end forms edges and UV deltas in the cycle the closing vertex
// arrives and writes a job into a two-entry queue. The back end runs it
// on one shared 33x33 multiplier (14 products), then per vector: a load
// step, a shift search, 3 squares, a 31-step square root and three
// divisions on one bit-serial divider (one load step, then one quotient
// bit per cycle). The back end takes a new job only when idle; a zero
// UV determinant goes straight to the result. Vertices keep flowing
// into the front end.
// A finished result waits in the output register while the next job runs.
// Reset clears held vertices, the vertex phase and both queues.
`timescale 1ns / 1ps
module triangle_tangent_frame (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  ttf_pkg::vtx_t vtx_i,
  output logic          empty,
  input  logic          pop,
  output ttf_pkg::res_t res_o
);
  import ttf_pkg::*;

  qstat_t qstat;
  job_t   job_w, job_r;
  logic   job_wr, job_rd;

  ttf_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .vtx_i    (vtx_i),
    .full_o   (full),
    .qstat_i  (qstat),
    .job_wr_o (job_wr),
    .job_o    (job_w)
  );

  ttf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (job_wr),
    .wdata_i (job_w),
    .rd_i    (job_rd),
    .rdata_o (job_r),
    .stat_o  (qstat)
  );

  ttf_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .qstat_i  (qstat),
    .job_i    (job_r),
    .job_rd_o (job_rd),
    .empty_o  (empty),
    .pop_i    (pop),
    .res_o    (res_o)
  );

endmodule
